/* design/bfs_pkg.sv */
package bfs_pkg;

  localparam int MAX_BOIDS_DEF = 64;

  localparam int POS_W  = 32;
  localparam int DIR_W  = 16;
  localparam int SPD_W  = 16;
  localparam int RAD_W  = 23;
  localparam int RAD2_W = 2 * RAD_W;
  localparam int CNTR_W = 7;
  localparam int CFGD_W = 23;
  localparam int CFGI_W = 3;

  // register reset values
  localparam logic [CNTR_W-1:0] RST_BOID_COUNT = 7'd64;
  localparam logic [RAD2_W-1:0] RST_ALIGN_R2   = 46'd966367641600;   // 15.0 squared
  localparam logic [RAD2_W-1:0] RST_COHES_R2   = 46'd3865470566400;  // 30.0 squared
  localparam logic [RAD2_W-1:0] RST_SEPAR_R2   = 46'd966367641600;   // 15.0 squared
  localparam logic [SPD_W-1:0]  RST_START_SPD  = 16'd12288;
  localparam logic [SPD_W-1:0]  RST_MAX_SPD    = 16'd4096;
  localparam logic [RAD_W-1:0]  RST_WRAP_RANGE = 23'd1966080;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_t;

  typedef enum logic [CFGI_W-1:0] {
    REG_BOID_COUNT        = 3'd0,
    REG_ALIGN_RADIUS      = 3'd1,
    REG_COHESION_RADIUS   = 3'd2,
    REG_SEPARATION_RADIUS = 3'd3,
    REG_START_SPEED       = 3'd4,
    REG_MAX_SPEED         = 3'd5,
    REG_WRAP_RANGE        = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MDIV,
    ST_SUM,
    ST_NORM,
    ST_SQR,
    ST_ROOT,
    ST_NDIV,
    ST_MUL1,
    ST_MUL2,
    ST_MOVE
  } state_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_z;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_z;
    logic                    slowed;
  } boid_t;

  // add a rounded move delta, saturate to 32 bits, then wrap at +-rng
  function automatic logic signed [POS_W-1:0] move_wrap(
    input logic signed [POS_W-1:0] p,
    input logic                    neg,
    input logic [21:0]             d,
    input logic [RAD_W-1:0]        rng
  );
    logic signed [33:0] s;
    logic signed [33:0] r;
    logic signed [33:0] w;
    s = neg ? (34'(p) - $signed({12'd0, d})) : (34'(p) + $signed({12'd0, d}));
    r = $signed({11'd0, rng});
    if (s > 34'sd2147483647) begin
      s = 34'sd2147483647;
    end
    if (s < -34'sd2147483648) begin
      s = -34'sd2147483648;
    end
    w = (s > r) ? -r : s;
    if (w < -r) begin
      w = r;
    end
    return w[POS_W-1:0];
  endfunction

endpackage

/* design/bfs_cell.sv */
module bfs_cell import bfs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  shift,
  input  logic  wr,
  input  boid_t wr_data,
  input  boid_t shift_in,
  output boid_t q
);

  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_z;
  logic signed [DIR_W-1:0] dir_x;
  logic signed [DIR_W-1:0] dir_z;
  logic                    slowed;

  always_ff @(posedge clk) begin
    if (wr) begin
      pos_x <= wr_data.pos_x;
      pos_z <= wr_data.pos_z;
      dir_x <= wr_data.dir_x;
      dir_z <= wr_data.dir_z;
    end else if (shift) begin
      pos_x <= shift_in.pos_x;
      pos_z <= shift_in.pos_z;
      dir_x <= shift_in.dir_x;
      dir_z <= shift_in.dir_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slowed <= 1'b0;
    end else if (wr) begin
      slowed <= wr_data.slowed;
    end else if (shift) begin
      slowed <= shift_in.slowed;
    end
  end

  assign q = '{pos_x: pos_x, pos_z: pos_z, dir_x: dir_x, dir_z: dir_z, slowed: slowed};

endmodule

/* design/bfs_div.sv */
module bfs_div #(
  parameter int NW = 46,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CNW = $clog2(NW + 1);

  logic [DW-1:0]  rem;
  logic [NW-1:0]  q;
  logic [DW-1:0]  dreg;
  logic [CNW-1:0] cnt;
  logic           run;
  logic [DW:0]    trial;
  logic           fits;

  // restoring division, one quotient bit a cycle
  assign trial = {rem, q[NW-1]};
  assign fits  = trial >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNW'(NW);
      end else if (run) begin
        cnt <= cnt - CNW'(1);
        if (cnt == CNW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      q    <= num;
      dreg <= den;
    end else if (run) begin
      rem <= fits ? (trial[DW-1:0] - dreg) : trial[DW-1:0];
      q   <= {q[NW-2:0], fits};
    end
  end

  assign quo = q;

endmodule

/* design/bfs_sqrt.sv */
module bfs_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] n_r;
  logic [63:0] r;
  logic [63:0] bitv;
  logic [5:0]  cnt;
  logic        run;
  logic [63:0] trial;
  logic        ge;

  // digit-by-digit root, one result bit a cycle
  assign trial = r + bitv;
  assign ge    = n_r >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 6'd32;
      end else if (run) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r  <= num;
      r    <= '0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (run) begin
      if (ge) begin
        n_r <= n_r - trial;
        r   <= (r >> 1) + bitv;
      end else begin
        r <= r >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  assign root = r[31:0];

endmodule

/* design/boid_flock_step_core.sv */
// Boid flock step core.
// Command channel: start/busy. A word is taken on a clock edge with start high and
// busy low. command = load writes one boid (index, position, direction) into its
// slot at once and clears its slowed flag; busy stays low. command = step runs one
// flock update over boids 0..n-1 in place and holds busy high until done.
// Result channel: out_valid strobes for one cycle per boid, in index order, with
// last set on boid n-1. There is no back-pressure on results.
// Config port: cfg_we/cfg_index/cfg_data. The user must write it only while idle;
// the block itself does not enforce this. Boids live in a ring of MAX_BOIDS cells
// that rotates one slot a cycle while scanning. Per boid: one lap picks the subject,
// a second lap streams every other boid through a 3-stage distance pipe, then six
// mean divisions on a shared bit-serial divider (NW = 46 at the default size), a
// sum, halving while the raw direction is too wide, a square, a digit-by-digit
// square root, two normalize divisions on the same divider, two multiplies, and
// the move with write-back.
// Reset clears the state machine, the slowed flags and loads the default registers;
// positions and directions are undefined until loaded.
module boid_flock_step_core import bfs_pkg::*; #(
  parameter int MAX_BOIDS = MAX_BOIDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           command,
  input  logic [$clog2(MAX_BOIDS)-1:0]   boid_index,
  input  logic signed [POS_W-1:0]        pos_x,
  input  logic signed [POS_W-1:0]        pos_z,
  input  logic signed [DIR_W-1:0]        dir_x,
  input  logic signed [DIR_W-1:0]        dir_z,
  input  logic [15:0]                    step_time,
  output logic                           out_valid,
  output logic [$clog2(MAX_BOIDS)-1:0]   out_index,
  output logic signed [POS_W-1:0]        out_pos_x,
  output logic signed [POS_W-1:0]        out_pos_z,
  output logic signed [DIR_W-1:0]        out_dir_x,
  output logic signed [DIR_W-1:0]        out_dir_z,
  output logic                           last,
  input  logic                           cfg_we,
  input  logic [CFGI_W-1:0]              cfg_index,
  input  logic [CFGD_W-1:0]              cfg_data
);

  localparam int IW  = $clog2(MAX_BOIDS);
  localparam int CW  = $clog2(MAX_BOIDS + 1);
  localparam int SCW = $clog2(2 * MAX_BOIDS + 2);
  localparam int AW  = 34 + IW;             // neighbour sums
  localparam int RW  = AW + 3;              // raw direction
  localparam int NW  = (AW > 46) ? AW : 46; // divider dividend
  localparam int DW  = 32;

  // ---------------- configuration registers ----------------
  logic [CNTR_W-1:0] boid_count;
  logic [RAD2_W-1:0] ra2, rc2, rs2;         // radii kept squared
  logic [SPD_W-1:0]  start_speed, max_speed;
  logic [RAD_W-1:0]  wrap_range;
  logic [RAD2_W-1:0] rad_sq;

  assign rad_sq = RAD2_W'(cfg_data) * RAD2_W'(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      boid_count  <= RST_BOID_COUNT;
      ra2         <= RST_ALIGN_R2;
      rc2         <= RST_COHES_R2;
      rs2         <= RST_SEPAR_R2;
      start_speed <= RST_START_SPD;
      max_speed   <= RST_MAX_SPD;
      wrap_range  <= RST_WRAP_RANGE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BOID_COUNT:        boid_count  <= cfg_data[CNTR_W-1:0];
        REG_ALIGN_RADIUS:      ra2         <= rad_sq;
        REG_COHESION_RADIUS:   rc2         <= rad_sq;
        REG_SEPARATION_RADIUS: rs2         <= rad_sq;
        REG_START_SPEED:       start_speed <= cfg_data[SPD_W-1:0];
        REG_MAX_SPEED:         max_speed   <= cfg_data[SPD_W-1:0];
        REG_WRAP_RANGE:        wrap_range  <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // boid count clamped to 1..MAX_BOIDS
  logic [CW-1:0] neff;
  always_comb begin
    if (boid_count == '0) begin
      neff = CW'(1);
    end else if (32'(boid_count) > MAX_BOIDS) begin
      neff = CW'(MAX_BOIDS);
    end else begin
      neff = CW'(boid_count);
    end
  end

  // ---------------- control ----------------
  state_t         state, state_next;
  logic [SCW-1:0] scnt;
  logic [IW-1:0]  idx;
  logic [2:0]     div_k;
  logic           unit_wait;
  logic [CW-1:0]  neff_r;
  logic [15:0]    t_r;
  logic           ring_shift, cell_wr_load, cell_wr_back;
  logic           div_start, sqrt_start, div_done, sqrt_done;
  logic           big, last_boid;
  logic           step_go;

  assign step_go   = start && !busy && (command == CMD_STEP);
  assign last_boid = CW'(idx) == (neff_r - CW'(1));

  // ---------------- ring of cells ----------------
  boid_t cell_q [MAX_BOIDS];
  boid_t wr_data, wb_data;
  boid_t head;

  assign head = cell_q[0];

  for (genvar k = 0; k < MAX_BOIDS; k++) begin : g_cell
    logic we_k;
    assign we_k = (cell_wr_load && boid_index == IW'(k)) ||
                  (cell_wr_back && idx == IW'(k));
    bfs_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (ring_shift),
      .wr       (we_k),
      .wr_data  (wr_data),
      .shift_in (cell_q[(k + 1) % MAX_BOIDS]),
      .q        (cell_q[k])
    );
  end

  assign wr_data = cell_wr_load ?
                   '{pos_x: pos_x, pos_z: pos_z, dir_x: dir_x, dir_z: dir_z, slowed: 1'b0} :
                   wb_data;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start && command == CMD_STEP) state_next = ST_SCAN;
      ST_SCAN: if (scnt == SCW'(2 * MAX_BOIDS + 1)) state_next = ST_MDIV;
      ST_MDIV: if (div_done && div_k == 3'd5) state_next = ST_SUM;
      ST_SUM:  state_next = ST_NORM;
      ST_NORM: if (!big) state_next = ST_SQR;
      ST_SQR:  state_next = ST_ROOT;
      ST_ROOT: if (sqrt_done) state_next = ST_NDIV;
      ST_NDIV: if (div_done && div_k == 3'd7) state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_MOVE;
      ST_MOVE: state_next = last_boid ? ST_IDLE : ST_SCAN;
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy         = 1'b1;
    ring_shift   = 1'b0;
    cell_wr_load = 1'b0;
    cell_wr_back = 1'b0;
    div_start    = 1'b0;
    sqrt_start   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy         = 1'b0;
        cell_wr_load = start && (command == CMD_LOAD);
      end
      ST_SCAN: ring_shift = scnt < SCW'(2 * MAX_BOIDS);
      ST_MDIV, ST_NDIV: div_start = !unit_wait;
      ST_ROOT: sqrt_start = !unit_wait;
      ST_MOVE: cell_wr_back = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      unit_wait <= 1'b0;
      out_valid <= 1'b0;
      scnt      <= '0;
      idx       <= '0;
      div_k     <= '0;
    end else begin
      state     <= state_next;
      out_valid <= (state == ST_MOVE);
      if (div_start || sqrt_start) begin
        unit_wait <= 1'b1;
      end else if (div_done || sqrt_done) begin
        unit_wait <= 1'b0;
      end
      if (step_go) begin
        idx  <= '0;
        scnt <= '0;
      end else if (state == ST_SCAN) begin
        scnt <= scnt + SCW'(1);
        div_k <= '0;
      end else if (state == ST_MOVE) begin
        idx  <= idx + IW'(1);
        scnt <= '0;
      end
      if (div_done) begin
        div_k <= div_k + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      neff_r <= neff;
      t_r    <= step_time;
    end
  end

  // ---------------- scan: subject pick and neighbour pipe ----------------
  boid_t          sub;
  logic           pass2;
  logic [SCW-1:0] jfull;
  logic           s1_v;
  logic signed [32:0] diffx, diffz;
  logic [32:0]    adx, adz;
  logic           near;

  assign pass2 = (scnt >= SCW'(MAX_BOIDS)) && (scnt < SCW'(2 * MAX_BOIDS));
  assign jfull = pass2 ? (scnt - SCW'(MAX_BOIDS)) : scnt;
  assign s1_v  = (state == ST_SCAN) && pass2 && (jfull < SCW'(neff_r)) &&
                 (jfull[IW-1:0] != idx);

  assign diffx = 33'(sub.pos_x) - 33'(head.pos_x);
  assign diffz = 33'(sub.pos_z) - 33'(head.pos_z);
  assign adx   = diffx[32] ? 33'(-diffx) : 33'(diffx);
  assign adz   = diffz[32] ? 33'(-diffz) : 33'(diffz);
  assign near  = (adx[32:23] == '0) && (adz[32:23] == '0);

  always_ff @(posedge clk) begin
    if (state == ST_SCAN && scnt < SCW'(MAX_BOIDS) && jfull[IW-1:0] == idx) begin
      sub <= head;
    end
  end

  logic                    p1_v, p2_v;
  logic [22:0]             p1_adx, p1_adz;
  logic signed [32:0]      p1_dx, p1_dz, p2_dx, p2_dz;
  logic signed [POS_W-1:0] p1_ox, p1_oz, p2_ox, p2_oz;
  logic signed [DIR_W-1:0] p1_odx, p1_odz, p2_odx, p2_odz;
  logic [RAD2_W-1:0]       p2_sqx, p2_sqz;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
    end else begin
      p1_v <= s1_v && near;
      p2_v <= p1_v;
    end
  end

  always_ff @(posedge clk) begin
    p1_adx <= adx[22:0];
    p1_adz <= adz[22:0];
    p1_dx  <= diffx;
    p1_dz  <= diffz;
    p1_ox  <= head.pos_x;
    p1_oz  <= head.pos_z;
    p1_odx <= head.dir_x;
    p1_odz <= head.dir_z;
    p2_sqx <= RAD2_W'(p1_adx) * RAD2_W'(p1_adx);
    p2_sqz <= RAD2_W'(p1_adz) * RAD2_W'(p1_adz);
    p2_dx  <= p1_dx;
    p2_dz  <= p1_dz;
    p2_ox  <= p1_ox;
    p2_oz  <= p1_oz;
    p2_odx <= p1_odx;
    p2_odz <= p1_odz;
  end

  // accumulate the three rule sums
  logic signed [AW-1:0] sax, saz, scx, scz, ssx, ssz;
  logic [IW-1:0]        ca, cc, cs;
  logic [RAD2_W:0]      d2;

  assign d2 = (RAD2_W + 1)'(p2_sqx) + (RAD2_W + 1)'(p2_sqz);

  always_ff @(posedge clk) begin
    if (state == ST_SCAN && scnt == '0) begin
      sax <= '0; saz <= '0; scx <= '0; scz <= '0; ssx <= '0; ssz <= '0;
      ca  <= '0; cc  <= '0; cs  <= '0;
    end else if (p2_v) begin
      if (d2 < (RAD2_W + 1)'(ra2)) begin
        sax <= sax + AW'(p2_odx);
        saz <= saz + AW'(p2_odz);
        ca  <= ca + IW'(1);
      end
      if (d2 < (RAD2_W + 1)'(rc2)) begin
        scx <= scx + AW'(p2_ox);
        scz <= scz + AW'(p2_oz);
        cc  <= cc + IW'(1);
      end
      if (d2 < (RAD2_W + 1)'(rs2)) begin
        ssx <= ssx + AW'(p2_dx);
        ssz <= ssz + AW'(p2_dz);
        cs  <= cs + IW'(1);
      end
    end
  end

  // ---------------- shared divider ----------------
  logic signed [AW-1:0] snum;
  logic [IW-1:0]        scnt_den;
  logic                 dneg;
  logic [AW-1:0]        dmag;
  logic [NW-1:0]        div_num, quo;
  logic [DW-1:0]        div_den;
  logic [RW-1:0]        ma, mb;
  logic [DW-1:0]        len;

  always_comb begin
    snum     = sax;
    scnt_den = ca;
    case (div_k)
      3'd0: begin snum = sax; scnt_den = ca; end
      3'd1: begin snum = saz; scnt_den = ca; end
      3'd2: begin snum = scx; scnt_den = cc; end
      3'd3: begin snum = scz; scnt_den = cc; end
      3'd4: begin snum = ssx; scnt_den = cs; end
      3'd5: begin snum = ssz; scnt_den = cs; end
      default: ;
    endcase
    dneg = snum[AW-1];
    dmag = dneg ? AW'(-snum) : AW'(snum);
    if (div_k[2:1] == 2'b11) begin
      div_num = NW'({div_k[0] ? mb[30:0] : ma[30:0], 14'd0}) + NW'(len >> 1);
      div_den = len;
    end else begin
      div_num = NW'(dmag);
      div_den = DW'(scnt_den);
    end
  end

  bfs_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  logic signed [AW-1:0] m_ax, m_az, m_cx, m_cz, m_sx, m_sz, sq_mean;
  logic [14:0]          qn_x, qn_z;

  assign sq_mean = dneg ? -AW'(quo) : AW'(quo);

  always_ff @(posedge clk) begin
    if (div_done) begin
      case (div_k)
        3'd0: m_ax <= sq_mean;
        3'd1: m_az <= sq_mean;
        3'd2: m_cx <= sq_mean;
        3'd3: m_cz <= sq_mean;
        3'd4: m_sx <= sq_mean;
        3'd5: m_sz <= sq_mean;
        3'd6: qn_x <= quo[14:0];
        default: qn_z <= quo[14:0];
      endcase
    end
  end

  // ---------------- raw direction and normalize ----------------
  logic signed [RW-1:0] dx4, dz4, rx, rz;
  always_comb begin
    dx4 = RW'(sub.dir_x) <<< 2;
    dz4 = RW'(sub.dir_z) <<< 2;
    rx  = dx4;
    rz  = dz4;
    if (ca != '0) begin
      rx = rx + ((RW'(m_ax) - RW'(sub.dir_x)) <<< 2);
      rz = rz + ((RW'(m_az) - RW'(sub.dir_z)) <<< 2);
    end
    if (cc != '0) begin
      rx = rx + RW'(m_cx) - RW'(sub.pos_x) - dx4;
      rz = rz + RW'(m_cz) - RW'(sub.pos_z) - dz4;
    end
    if (cs != '0) begin
      rx = rx + RW'(m_sx) - dx4;
      rz = rz + RW'(m_sz) - dz4;
    end
  end

  assign big = (|ma[RW-1:31]) || (|mb[RW-1:31]);

  logic        sgn_x, sgn_z, slow_new;
  logic [61:0] sqa, sqb;
  logic [31:0] root;

  always_ff @(posedge clk) begin
    if (state == ST_SUM) begin
      ma       <= rx[RW-1] ? RW'(-rx) : RW'(rx);
      mb       <= rz[RW-1] ? RW'(-rz) : RW'(rz);
      sgn_x    <= rx[RW-1];
      sgn_z    <= rz[RW-1];
      slow_new <= sub.slowed || (cc != '0) || (cs != '0);
    end else if (state == ST_NORM && big) begin
      ma <= ma >> 1;
      mb <= mb >> 1;
    end
    if (state == ST_SQR) begin
      sqa <= 62'(ma[30:0]) * 62'(ma[30:0]);
      sqb <= 62'(mb[30:0]) * 62'(mb[30:0]);
    end
    if (sqrt_done) begin
      len <= root;
    end
  end

  bfs_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .num   (64'(sqa) + 64'(sqb)),
    .done  (sqrt_done),
    .root  (root)
  );

  // ---------------- move ----------------
  logic [14:0]             amx, amz;
  logic [SPD_W-1:0]        speed;
  logic signed [DIR_W-1:0] nx, nz;
  logic [30:0]             pr1x, pr1z;
  logic [46:0]             pr2x, pr2z;
  logic [21:0]             dlx, dlz;
  logic signed [POS_W-1:0] npx, npz;

  assign amx   = (len == '0) ? 15'd0 : qn_x;
  assign amz   = (len == '0) ? 15'd0 : qn_z;
  assign speed = slow_new ? max_speed : start_speed;

  always_ff @(posedge clk) begin
    if (state == ST_MUL1) begin
      nx   <= sgn_x ? -DIR_W'(amx) : DIR_W'(amx);
      nz   <= sgn_z ? -DIR_W'(amz) : DIR_W'(amz);
      pr1x <= 31'(amx) * 31'(speed);
      pr1z <= 31'(amz) * 31'(speed);
    end
    if (state == ST_MUL2) begin
      pr2x <= 47'(pr1x) * 47'(t_r);
      pr2z <= 47'(pr1z) * 47'(t_r);
    end
  end

  assign dlx = 22'((48'(pr2x) + 48'd33554432) >> 26);
  assign dlz = 22'((48'(pr2z) + 48'd33554432) >> 26);
  assign npx = move_wrap(sub.pos_x, nx[DIR_W-1], dlx, wrap_range);
  assign npz = move_wrap(sub.pos_z, nz[DIR_W-1], dlz, wrap_range);

  assign wb_data = '{pos_x: npx, pos_z: npz, dir_x: nx, dir_z: nz, slowed: slow_new};

  always_ff @(posedge clk) begin
    if (state == ST_MOVE) begin
      out_index <= idx;
      out_pos_x <= npx;
      out_pos_z <= npz;
      out_dir_x <= nx;
      out_dir_z <= nz;
      last      <= last_boid;
    end
  end

  // ---------------- checks ----------------
  a_out_from_move: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(state == ST_MOVE))
    else $error("result strobe without a finished boid");

  a_last_ends_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> !busy)
    else $error("still busy after last boid");

  a_step_goes_busy: assert property (@(posedge clk) disable iff (rst)
    step_go |=> busy)
    else $error("step accepted but not busy");

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(div_start && sqrt_start) && !((div_start || sqrt_start) && unit_wait))
    else $error("arithmetic unit started while in use");

endmodule

/* tb/boid_checker.sv */
`timescale 1ns / 1ps
// Watches the command, result and register ports of the flock core,
// predicts every boid word of a step and compares field by field.
module boid_checker import bfs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic              command,
  input  logic [5:0]        boid_index,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_z,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_z,
  input  logic [15:0]       step_time,
  input  logic              out_valid,
  input  logic [5:0]        out_index,
  input  logic signed [31:0] out_pos_x,
  input  logic signed [31:0] out_pos_z,
  input  logic signed [15:0] out_dir_x,
  input  logic signed [15:0] out_dir_z,
  input  logic              last,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [22:0]       cfg_data,
  output int                errors,
  output int                pending
);

  typedef struct {
    logic [5:0]         idx;
    logic signed [31:0] px;
    logic signed [31:0] pz;
    logic signed [15:0] dx;
    logic signed [15:0] dz;
    logic               lst;
  } boid_word_t;

  boid_word_t flock_q[$];

  // flock state and register copies
  longint     fpx[64], fpz[64], fdx[64], fdz[64];
  bit         slowed[64];
  longint     n_cfg, r_align, r_cohes, r_separ, spd_start, spd_max, wrap;

  function automatic longint unsigned magn(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // scale a raw Q16 heading to a Q1.14 unit vector
  function automatic void unit_dir(longint a, longint b, output longint oa, output longint ob);
    longint unsigned ma, mb, len, qa, qb;
    ma = magn(a);
    mb = magn(b);
    while (ma >= (64'd1 << 31) || mb >= (64'd1 << 31)) begin
      ma = ma >> 1;
      mb = mb >> 1;
    end
    len = int_sqrt(ma * ma + mb * mb);
    if (len == 0) begin
      oa = 0;
      ob = 0;
      return;
    end
    qa = (ma * 16384 + len / 2) / len;
    qb = (mb * 16384 + len / 2) / len;
    oa = a < 0 ? -longint'(qa) : longint'(qa);
    ob = b < 0 ? -longint'(qb) : longint'(qb);
  endfunction

  function automatic longint glide(longint p, longint d, longint unsigned spd,
                                   longint unsigned t);
    longint unsigned m;
    longint dl;
    m = magn(d) * spd * t;
    dl = longint'((m + (64'd1 << 25)) >> 26);
    p = d < 0 ? p - dl : p + dl;
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    if (p > wrap) p = -wrap;
    if (p < -wrap) p = wrap;
    return p;
  endfunction

  // one in-place flock update; pushes one expected word per boid
  task automatic fly_flock(longint unsigned t);
    longint n, ra2, rc2, rs2;
    longint px, pz, dx, dz, sax, saz, scx, scz, ssx, ssz, ca, cc, cs, ax, az, nx, nz;
    longint adx, adz, d2;
    longint unsigned spd;
    boid_word_t w;
    n = n_cfg < 1 ? 1 : (n_cfg > 64 ? 64 : n_cfg);
    ra2 = r_align * r_align;
    rc2 = r_cohes * r_cohes;
    rs2 = r_separ * r_separ;
    for (int i = 0; i < n; i++) begin
      px = fpx[i]; pz = fpz[i]; dx = fdx[i]; dz = fdz[i];
      sax = 0; saz = 0; scx = 0; scz = 0; ssx = 0; ssz = 0; ca = 0; cc = 0; cs = 0;
      for (int j = 0; j < n; j++) begin
        if (j == i) continue;
        adx = magn(fpx[j] - px);
        adz = magn(fpz[j] - pz);
        if (adx >= (64'd1 << 23) || adz >= (64'd1 << 23)) continue;
        d2 = adx * adx + adz * adz;
        if (d2 < ra2) begin sax += fdx[j]; saz += fdz[j]; ca++; end
        if (d2 < rc2) begin scx += fpx[j]; scz += fpz[j]; cc++; end
        if (d2 < rs2) begin ssx += px - fpx[j]; ssz += pz - fpz[j]; cs++; end
      end
      ax = 0; az = 0;
      if (ca != 0) begin
        ax += (sax / ca - dx) * 4;
        az += (saz / ca - dz) * 4;
      end
      if (cc != 0) begin
        ax += scx / cc - px - dx * 4;
        az += scz / cc - pz - dz * 4;
        slowed[i] = 1;
      end
      if (cs != 0) begin
        ax += ssx / cs - dx * 4;
        az += ssz / cs - dz * 4;
        slowed[i] = 1;
      end
      unit_dir(dx * 4 + ax, dz * 4 + az, nx, nz);
      spd = slowed[i] ? spd_max : spd_start;
      px = glide(px, nx, spd, t);
      pz = glide(pz, nz, spd, t);
      fpx[i] = px; fpz[i] = pz; fdx[i] = nx; fdz[i] = nz;
      w.idx = i[5:0];
      w.px = px[31:0];
      w.pz = pz[31:0];
      w.dx = nx[15:0];
      w.dz = nz[15:0];
      w.lst = (i == n - 1);
      flock_q.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    boid_word_t e;
    if (rst) begin
      errors = 0;
      n_cfg = 64; r_align = 983040; r_cohes = 1966080; r_separ = 983040;
      spd_start = 12288; spd_max = 4096; wrap = 1966080;
      for (int k = 0; k < 64; k++) begin
        fpx[k] = 0; fpz[k] = 0; fdx[k] = 0; fdz[k] = 0; slowed[k] = 0;
      end
    end else begin
      // result word
      if (out_valid) begin
        if (flock_q.size() == 0) begin
          $error("boid word for slot %0d with nothing expected", out_index);
          errors++;
        end else begin
          e = flock_q.pop_front();
          if (out_index !== e.idx) begin
            $error("out_index expected %0d got %0d", e.idx, out_index); errors++;
          end
          if (out_pos_x !== e.px) begin
            $error("out_pos_x expected %0d got %0d", e.px, out_pos_x); errors++;
          end
          if (out_pos_z !== e.pz) begin
            $error("out_pos_z expected %0d got %0d", e.pz, out_pos_z); errors++;
          end
          if (out_dir_x !== e.dx) begin
            $error("out_dir_x expected %0d got %0d", e.dx, out_dir_x); errors++;
          end
          if (out_dir_z !== e.dz) begin
            $error("out_dir_z expected %0d got %0d", e.dz, out_dir_z); errors++;
          end
          if (last !== e.lst) begin
            $error("last expected %0d got %0d", e.lst, last); errors++;
          end
        end
      end
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_BOID_COUNT:        n_cfg = cfg_data[6:0];
          REG_ALIGN_RADIUS:      r_align = cfg_data;
          REG_COHESION_RADIUS:   r_cohes = cfg_data;
          REG_SEPARATION_RADIUS: r_separ = cfg_data;
          REG_START_SPEED:       spd_start = cfg_data[15:0];
          REG_MAX_SPEED:         spd_max = cfg_data[15:0];
          REG_WRAP_RANGE:        wrap = cfg_data;
          default: ;
        endcase
      end
      // command word
      if (start && !busy) begin
        if (cmd_t'(command) == CMD_LOAD) begin
          fpx[boid_index] = pos_x;
          fpz[boid_index] = pos_z;
          fdx[boid_index] = dir_x;
          fdz[boid_index] = dir_z;
          slowed[boid_index] = 0;
        end else begin
          fly_flock(step_time);
        end
      end
    end
    pending = flock_q.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Flock core bench: directed loads and steps, then phases of random loads and
// steps under several register settings. Checking lives in boid_checker.
module testbench import bfs_pkg::*;;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int NEAR = 2621440;   // +-40.0 in Q15.16, keeps boids in contact

  logic              clk, rst;
  logic              start, busy, command;
  logic [5:0]        boid_index;
  logic signed [31:0] pos_x, pos_z;
  logic signed [15:0] dir_x, dir_z;
  logic [15:0]       step_time;
  logic              out_valid, last;
  logic [5:0]        out_index;
  logic signed [31:0] out_pos_x, out_pos_z;
  logic signed [15:0] out_dir_x, out_dir_z;
  logic              cfg_we;
  logic [2:0]        cfg_index;
  logic [22:0]       cfg_data;
  int                errors, pending, cycles;
  bit                gaps_on;
  bit                loaded[64];   // slots ever loaded; a step never reads an unloaded one

  boid_flock_step_core i_dut (.*);

  boid_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL boid_flock_step_core");
      $finish;
    end
  end

  function automatic logic [31:0] rand_pos();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return $urandom_range(0, 2 * NEAR) - NEAR;
  endfunction

  function automatic logic [15:0] rand_dir();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  // one command word; start held until the core takes it
  task automatic send_word(cmd_t c, logic [5:0] idx, logic [31:0] px, logic [31:0] pz,
                           logic [15:0] dx, logic [15:0] dz, logic [15:0] t);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    start <= 1'b1;
    command <= c;
    boid_index <= idx;
    pos_x <= px;
    pos_z <= pz;
    dir_x <= dx;
    dir_z <= dz;
    step_time <= t;
    do @(posedge clk); while (busy);
    if (c == CMD_LOAD) loaded[idx] = 1'b1;
  endtask

  task automatic load_rand(logic [5:0] idx);
    send_word(CMD_LOAD, idx, rand_pos(), rand_pos(), rand_dir(), rand_dir(), 16'($urandom));
  endtask

  // drain: no word pending and the core back at idle
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    cfg_we <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // cfg_we is left high; the next word or drain lowers it
  task automatic wr_reg(reg_idx_t r, logic [22:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
  endtask

  task automatic set_regs(logic [22:0] n, logic [22:0] ra, logic [22:0] rc,
                          logic [22:0] rs, logic [22:0] ss, logic [22:0] ms,
                          logic [22:0] wr);
    settle();
    wr_reg(REG_BOID_COUNT, n);
    wr_reg(REG_ALIGN_RADIUS, ra);
    wr_reg(REG_COHESION_RADIUS, rc);
    wr_reg(REG_SEPARATION_RADIUS, rs);
    wr_reg(REG_START_SPEED, ss);
    wr_reg(REG_MAX_SPEED, ms);
    wr_reg(REG_WRAP_RANGE, wr);
  endtask

  // random phase: mostly loads near the flock, some steps
  task automatic run_phase(int n_words, int n_eff, int steps_pct);
    for (int k = 0; k < n_words; k++) begin
      for (int s = 0; s < n_eff; s++) if (!loaded[s]) load_rand(s[5:0]);
      if ($urandom_range(0, 99) < steps_pct)
        send_word(CMD_STEP, 6'($urandom), $urandom, $urandom, 16'($urandom),
                  16'($urandom), 16'($urandom));
      else
        load_rand(6'($urandom_range(0, 63)));
    end
  endtask

  initial begin
    int nr;
    rst = 1'b1;
    start = 1'b0; command = 1'b0; boid_index = '0;
    pos_x = '0; pos_z = '0; dir_x = '0; dir_z = '0; step_time = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    gaps_on = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: a 4 boid flock at field extremes
    set_regs(4, 983040, 1966080, 983040, 12288, 4096, 1966080);
    send_word(CMD_LOAD, 0, 0, 0, 16'sd16384, 0, 0);
    send_word(CMD_LOAD, 1, 32'sd327680, 0, -16'sd32768, 16'sd32767, 0);
    send_word(CMD_LOAD, 2, 32'h7fffffff, 32'h80000000, 0, 0, 16'hffff);
    send_word(CMD_LOAD, 3, 32'h80000000, 32'h7fffffff, 16'sd32767, -16'sd32768, 0);
    send_word(CMD_STEP, 0, 0, 0, 0, 0, 16'hffff);
    send_word(CMD_STEP, 63, 0, 0, 0, 0, 0);
    // two boids on one spot with zero heading: zero length normalize
    send_word(CMD_LOAD, 2, 0, 0, 0, 0, 0);
    send_word(CMD_LOAD, 3, 0, 0, 0, 0, 0);
    send_word(CMD_STEP, 0, 32'hffffffff, 32'hffffffff, 16'hffff, 16'hffff, 16'h8000);
    // reload clears slowed: start_speed again
    send_word(CMD_LOAD, 0, 32'sd65536, 32'sd65536, 16'sd16384, 16'sd16384, 0);
    send_word(CMD_STEP, 0, 0, 0, 0, 0, 16'h7fff);

    // count zero acts as one; zero radii and zero wrap
    set_regs(0, 0, 0, 0, 0, 23'h7fffff, 0);
    run_phase(10, 1, 40);
    // huge radii, top start speed and zero max speed, widest wrap
    set_regs(8, 23'h7fffff, 23'h7fffff, 23'h7fffff, 23'hffff, 0, 23'h7fffff);
    run_phase(12, 8, 30);
    // count above the pool acts as 64: the slow case, kept short
    set_regs(127, 23'($urandom_range(0, 3000000)), 23'($urandom_range(0, 3000000)),
             23'($urandom_range(0, 3000000)), 23'($urandom), 23'($urandom),
             23'($urandom));
    run_phase(4, 64, 25);
    for (int p = 0; p < 2; p++) begin
      nr = $urandom_range(2, 10);
      set_regs(23'(nr), 23'($urandom_range(0, 8388607) >> $urandom_range(0, 4)),
               23'($urandom_range(0, 8388607) >> $urandom_range(0, 4)),
               23'($urandom_range(0, 8388607) >> $urandom_range(0, 4)),
               23'($urandom), 23'($urandom), 23'($urandom));
      run_phase(10, nr, 30);
    end
    // last part without gaps, default-like flock
    set_regs(6, 983040, 1966080, 983040, 12288, 4096, 1966080);
    gaps_on = 1'b0;
    run_phase(12, 6, 35);

    settle();
    repeat (700) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS boid_flock_step_core");
    end else begin
      $display("FAIL boid_flock_step_core");
    end
    $finish;
  end

endmodule
